// File: src/mi2_pkg.sv
package mi2_pkg;

    typedef struct packed {
        logic signed [31:0] elem_a;
        logic signed [31:0] elem_b;
        logic signed [31:0] elem_c;
        logic signed [31:0] elem_d;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] inv_a;
        logic signed [31:0] inv_b;
        logic signed [31:0] inv_c;
        logic signed [31:0] inv_d;
        logic [1:0]         status;
    } t_out_word;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SINGULAR = 2'd1;
    localparam logic [1:0] STAT_SAT      = 2'd2;

    localparam int QBITS   = 32;
    localparam int NUM_W   = 96;
    localparam int NUM_ELS = 4;

endpackage

// File: src/matrix_inverse_2x2_core.sv
// An accepted input word passes through stages s1 to s4, the divide stages and the output register to its output word.
// Throughput: one word per cycle while the output is not stalled; 32 restoring divide stages, one quotient bit each,
// run four numerators in parallel against the shared determinant.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline.
module matrix_inverse_2x2_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mi2_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mi2_pkg::t_out_word o_out_word
);
    import mi2_pkg::*;

    localparam int SHIFT = 2 * FRAC_BITS;

    logic en;

    // front stages
    logic                r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_in_word            r_s1_in, r_s2_in, r_s3_in, r_s4_in;
    logic signed [63:0]  r_s2_p1, r_s2_p2;
    logic signed [64:0]  r_s3_det;
    logic [63:0]         r_s4_dmag;
    logic                r_s4_dneg;
    logic [31:0]         r_s4_mag [NUM_ELS];
    logic                r_s4_neg [NUM_ELS];

    // divide stages
    logic        r_dv_valid [QBITS+1];
    t_in_word    r_dv_in    [QBITS+1];
    logic [63:0] r_dv_det   [QBITS+1];
    logic        r_dv_sing  [QBITS+1];
    logic [63:0] r_dv_rem   [QBITS+1][NUM_ELS];
    logic [31:0] r_dv_q     [QBITS+1][NUM_ELS];
    logic [31:0] r_dv_nlo   [QBITS+1][NUM_ELS];
    logic        r_dv_rneg  [QBITS+1][NUM_ELS];
    logic        r_dv_ovf   [QBITS+1][NUM_ELS];

    logic [63:0] n_rem [QBITS][NUM_ELS];
    logic        n_bit [QBITS][NUM_ELS];

    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;

    logic [31:0] s3_mag [NUM_ELS];
    logic        s3_neg [NUM_ELS];
    logic [NUM_W-1:0] s4_num [NUM_ELS];
    logic [64:0] s3_det_abs;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // element magnitudes in result order: d, -b, -c, a
    always_comb begin
        s3_mag[0] = r_s3_in.elem_d[31] ? 32'(-r_s3_in.elem_d) : r_s3_in.elem_d;
        s3_mag[1] = r_s3_in.elem_b[31] ? 32'(-r_s3_in.elem_b) : r_s3_in.elem_b;
        s3_mag[2] = r_s3_in.elem_c[31] ? 32'(-r_s3_in.elem_c) : r_s3_in.elem_c;
        s3_mag[3] = r_s3_in.elem_a[31] ? 32'(-r_s3_in.elem_a) : r_s3_in.elem_a;
        s3_neg[0] = r_s3_in.elem_d[31];
        s3_neg[1] = !r_s3_in.elem_b[31];
        s3_neg[2] = !r_s3_in.elem_c[31];
        s3_neg[3] = r_s3_in.elem_a[31];
        s3_det_abs = r_s3_det[64] ? 65'(-r_s3_det) : r_s3_det;
        for (int e = 0; e < NUM_ELS; e++) begin
            s4_num[e] = NUM_W'(r_s4_mag[e]) << SHIFT;
        end
    end

    always_comb begin
        for (int k = 0; k < QBITS; k++) begin
            for (int e = 0; e < NUM_ELS; e++) begin
                logic [63:0] t;
                t = {r_dv_rem[k][e][62:0], r_dv_nlo[k][e][31]};
                n_bit[k][e] = (t >= r_dv_det[k]);
                n_rem[k][e] = n_bit[k][e] ? (t - r_dv_det[k]) : t;
            end
        end
    end

    always_comb begin
        logic [31:0] q, m, v [NUM_ELS];
        logic        sat, any_sat;
        any_sat = 1'b0;
        for (int e = 0; e < NUM_ELS; e++) begin
            q = r_dv_q[QBITS][e];
            sat = r_dv_ovf[QBITS][e] ||
                  (r_dv_rneg[QBITS][e] ? (q[31] && (|q[30:0])) : q[31]);
            if (sat) begin
                m = r_dv_rneg[QBITS][e] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
                m = q;
            end
            v[e] = r_dv_rneg[QBITS][e] ? 32'(-m) : m;
            any_sat = any_sat || sat;
        end
        if (r_dv_sing[QBITS]) begin
            n_out_word.inv_a  = r_dv_in[QBITS].elem_a;
            n_out_word.inv_b  = r_dv_in[QBITS].elem_b;
            n_out_word.inv_c  = r_dv_in[QBITS].elem_c;
            n_out_word.inv_d  = r_dv_in[QBITS].elem_d;
            n_out_word.status = STAT_SINGULAR;
        end else begin
            n_out_word.inv_a  = v[0];
            n_out_word.inv_b  = v[1];
            n_out_word.inv_c  = v[2];
            n_out_word.inv_d  = v[3];
            n_out_word.status = any_sat ? STAT_SAT : STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QBITS; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_dv_valid[0] <= r_s4_valid;
            for (int k = 0; k < QBITS; k++) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            r_out_valid <= r_dv_valid[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_in <= i_in_word;

            r_s2_in <= r_s1_in;
            r_s2_p1 <= 64'(r_s1_in.elem_a) * 64'(r_s1_in.elem_d);
            r_s2_p2 <= 64'(r_s1_in.elem_b) * 64'(r_s1_in.elem_c);

            r_s3_in  <= r_s2_in;
            r_s3_det <= 65'(r_s2_p1) - 65'(r_s2_p2);

            r_s4_in   <= r_s3_in;
            r_s4_dmag <= s3_det_abs[63:0];
            r_s4_dneg <= r_s3_det[64];
            for (int e = 0; e < NUM_ELS; e++) begin
                r_s4_mag[e] <= s3_mag[e];
                r_s4_neg[e] <= s3_neg[e];
            end

            r_dv_in[0]   <= r_s4_in;
            r_dv_det[0]  <= r_s4_dmag;
            r_dv_sing[0] <= (r_s4_dmag == 64'd0);
            for (int e = 0; e < NUM_ELS; e++) begin
                r_dv_ovf[0][e]  <= (s4_num[e][NUM_W-1:32] >= r_s4_dmag);
                r_dv_rem[0][e]  <= s4_num[e][NUM_W-1:32];
                r_dv_nlo[0][e]  <= s4_num[e][31:0];
                r_dv_q[0][e]    <= 32'd0;
                r_dv_rneg[0][e] <= r_s4_neg[e] ^ r_s4_dneg;
            end

            for (int k = 0; k < QBITS; k++) begin
                r_dv_in[k+1]   <= r_dv_in[k];
                r_dv_det[k+1]  <= r_dv_det[k];
                r_dv_sing[k+1] <= r_dv_sing[k];
                for (int e = 0; e < NUM_ELS; e++) begin
                    r_dv_ovf[k+1][e]  <= r_dv_ovf[k][e];
                    r_dv_rneg[k+1][e] <= r_dv_rneg[k][e];
                    r_dv_rem[k+1][e]  <= n_rem[k][e];
                    r_dv_nlo[k+1][e]  <= {r_dv_nlo[k][e][30:0], 1'b0};
                    r_dv_q[k+1][e]    <= {r_dv_q[k][e][30:0], n_bit[k][e]};
                end
            end

            r_out_word <= n_out_word;
        end
    end

endmodule
